// File: design/ntr_pkg.sv
// Shared types, constants and codes for the neighbor table resolver.
// No dependencies; every other file of the block but ntr_ram imports this package.
package ntr_pkg;

   // Field widths
   localparam int KEY_W  = 32;
   localparam int MAC_W  = 48;
   localparam int TYPE_W = 16;
   localparam int ID_W   = 16;
   localparam int WAIT_W = 16;
   localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

   // Default geometry
   localparam int DEF_BUCKETS = 64;
   localparam int DEF_WAYS    = 4;

   // Stream packing
   localparam int REQ_DATA_W   = KEY_W + MAC_W + TYPE_W + ID_W;
   localparam int RSP_FIELDS_W = 2*MAC_W + TYPE_W + ID_W + 2*KEY_W + 1 + WAIT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_OUTPUT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXISTS    = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_NO_ROOM   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE     = 2'd0,
      ACT_TRANSMIT = 2'd1,
      ACT_HOLD     = 2'd2
   } action_type;

   typedef enum logic [0:0] {
      REG_PORT_MAC = 1'b0,
      REG_PORT_IP  = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_MATCH,
      S_UPDATE
   } state_type;

   // One way of a bucket row
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [MAC_W-1:0]  mac;
      logic              resolved;
      logic [WAIT_W-1:0] waiting;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Result of the parallel way compare
   typedef struct packed {
      logic hit;
      logic room;
   } match_flags_type;

endpackage

// File: design/neighbor_table_resolver.sv
// Neighbor table resolver top level: request FSM, bucket row read-modify-write,
// result register. Depends on ntr_pkg, ntr_ram, ntr_bucket_hash, ntr_way_match.
//
// Hashed ARP neighbor cache. A request selects bucket next_hop_ip mod BUCKETS,
// reads that bucket's row of WAYS entries from one RAM, compares all ways at
// once and writes the row back for an add, delete or output that succeeds;
// every request yields exactly one response. Requests are handled one at a
// time, in the states index and row read (S_HASH), compare (S_MATCH) and
// update (S_UPDATE), where the response is loaded; the next request is
// accepted in S_IDLE after that. A BUCKETS that is not a power of two makes
// the remainder unit lengthen the index step. The row read-modify-write on
// the single RAM keeps requests from overlapping. The response register lets
// the next request be accepted while the previous response waits; a request
// stalls only in its update cycle if the response is still not taken. After
// reset the RAM is swept clear, one row per cycle, during which req_tready
// stays low; csr writes are taken at any time.
module neighbor_table_resolver #(
   parameter int BUCKETS = ntr_pkg::DEF_BUCKETS,
   parameter int WAYS    = ntr_pkg::DEF_WAYS
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: next_hop_ip[31:0], neighbor_mac[79:32], frame_proto[95:80], packet_id[111:96]
   input  logic [ntr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: mode[1:0]
   input  logic [1:0]                         req_tuser,
   // Response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: dst_mac[47:0], src_mac[95:48], hdr_proto[111:96], packet_ref[127:112],
   //        arp_target_ip[159:128], arp_sender_ip[191:160], resolved[192],
   //        waiting_count[208:193], zero pad[215:209]
   output logic [ntr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: status[1:0], action[3:2]
   output logic [3:0]                         rsp_tuser,
   // Configuration writes
   input  logic                               csr_wr_en,
   input  logic [0:0]                         csr_index,
   input  logic [ntr_pkg::MAC_W-1:0]          csr_wdata
);
   import ntr_pkg::*;

   localparam int BKT_W = $clog2(BUCKETS);
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W = WAYS + WAYS * ENTRY_W;

   // Configuration registers
   logic [MAC_W-1:0] port_mac_ff;
   logic [KEY_W-1:0] port_ip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_mac_ff <= '0;
         port_ip_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_PORT_MAC: port_mac_ff <= csr_wdata;
            REG_PORT_IP:  port_ip_ff  <= csr_wdata[KEY_W-1:0];
            default: ;
         endcase
      end
   end

   // Request capture
   logic             req_accept;
   mode_type         mode_ff;
   logic [KEY_W-1:0] key_ff;
   logic [MAC_W-1:0] mac_ff;
   logic [TYPE_W-1:0] ptype_ff;
   logic [ID_W-1:0]  pid_ff;

   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= mode_type'(req_tuser);
         key_ff   <= req_tdata[KEY_W-1:0];
         mac_ff   <= req_tdata[KEY_W +: MAC_W];
         ptype_ff <= req_tdata[KEY_W+MAC_W +: TYPE_W];
         pid_ff   <= req_tdata[KEY_W+MAC_W+TYPE_W +: ID_W];
      end
   end

   // Bucket index
   logic             hash_done;
   logic [BKT_W-1:0] hash_bucket;

   ntr_bucket_hash #(
      .BUCKETS (BUCKETS),
      .BKT_W   (BKT_W)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .key    (req_tdata[KEY_W-1:0]),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   // Bucket row memory: {used bits, entries}
   logic             ram_we, ram_re;
   logic [BKT_W-1:0] ram_waddr;
   logic [ROW_W-1:0] ram_wdata, rd_row;
   logic             upd_we;

   ntr_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (hash_bucket),
      .rd_data (rd_row)
   );

   logic [WAYS-1:0]            rd_used;
   entry_type [WAYS-1:0]       rd_ents;
   assign rd_used = rd_row[ROW_W-1 -: WAYS];
   assign rd_ents = rd_row[WAYS*ENTRY_W-1:0];

   // Way compare, registered for the update cycle
   match_flags_type  flags, flags_ff;
   logic [WAY_W-1:0] hit_way, free_way, hit_way_ff, free_way_ff;

   ntr_way_match #(
      .WAYS  (WAYS),
      .WAY_W (WAY_W)
   ) u_match (
      .key      (key_ff),
      .used     (rd_used),
      .ents     (rd_ents),
      .flags    (flags),
      .hit_way  (hit_way),
      .free_way (free_way)
   );

   // Control state
   state_type        state_ff, state_in;
   logic [BKT_W-1:0] clr_idx_ff;
   logic             rsp_valid_ff;
   logic             rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MATCH) begin
         flags_ff    <= flags;
         hit_way_ff  <= hit_way;
         free_way_ff <= free_way;
      end
   end

   // Next state and control outputs
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      ram_re     = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_idx_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               ram_re   = 1'b1;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Update of the selected way and the response fields
   logic [WAY_W-1:0]     sel_way;
   entry_type            cur_ent, new_ent, rep_ent;
   entry_type [WAYS-1:0] wr_ents;
   logic [WAYS-1:0]      wr_used;
   logic                 rep;
   status_type           status_in;
   action_type           action_in;

   always_comb begin
      sel_way   = flags_ff.hit ? hit_way_ff : free_way_ff;
      cur_ent   = rd_ents[sel_way];
      new_ent   = cur_ent;
      rep_ent   = cur_ent;
      wr_used   = rd_used;
      upd_we    = 1'b0;
      rep       = 1'b0;
      status_in = STATUS_OK;
      action_in = ACT_NONE;
      unique case (mode_ff)
         MODE_ADD: begin
            if (flags_ff.hit) begin
               status_in = STATUS_EXISTS;
               rep       = 1'b1;
            end else if (flags_ff.room) begin
               new_ent          = '{key: key_ff, mac: mac_ff, resolved: 1'b1, waiting: '0};
               wr_used[sel_way] = 1'b1;
               upd_we           = 1'b1;
               rep              = 1'b1;
               rep_ent          = new_ent;
            end else begin
               status_in = STATUS_NO_ROOM;
            end
         end
         MODE_DELETE: begin
            if (flags_ff.hit) begin
               wr_used[sel_way] = 1'b0;
               upd_we           = 1'b1;
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         MODE_LOOKUP: begin
            if (flags_ff.hit) begin
               rep = 1'b1;
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         MODE_OUTPUT: begin
            if (!flags_ff.hit && !flags_ff.room) begin
               status_in = STATUS_NO_ROOM;
            end else begin
               if (!flags_ff.hit) begin
                  new_ent = '{key: key_ff, mac: '0, resolved: 1'b0, waiting: '0};
               end
               if (new_ent.resolved) begin
                  action_in = ACT_TRANSMIT;
               end else begin
                  action_in = ACT_HOLD;
                  if (new_ent.waiting != WAIT_MAX) begin
                     new_ent.waiting = new_ent.waiting + 1'b1;
                  end
               end
               wr_used[sel_way] = 1'b1;
               upd_we           = 1'b1;
               rep              = 1'b1;
               rep_ent          = new_ent;
            end
         end
         default: ;
      endcase
      wr_ents          = rd_ents;
      wr_ents[sel_way] = new_ent;
   end

   // Memory write: clearing sweep or row write-back
   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_idx_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = rsp_load && upd_we;
         ram_waddr = hash_bucket;
         ram_wdata = {wr_used, wr_ents};
      end
   end

   // Response register
   status_type        rsp_status_ff;
   action_type        rsp_action_ff;
   logic [MAC_W-1:0]  rsp_dst_mac_ff, rsp_src_mac_ff;
   logic [TYPE_W-1:0] rsp_hdr_proto_ff;
   logic [ID_W-1:0]   rsp_packet_ref_ff;
   logic [KEY_W-1:0]  rsp_target_ip_ff, rsp_sender_ip_ff;
   logic              rsp_resolved_ff;
   logic [WAIT_W-1:0] rsp_waiting_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff     <= status_in;
         rsp_action_ff     <= action_in;
         rsp_dst_mac_ff    <= rep ? rep_ent.mac : '0;
         rsp_resolved_ff   <= rep ? rep_ent.resolved : 1'b0;
         rsp_waiting_ff    <= rep ? rep_ent.waiting : '0;
         rsp_src_mac_ff    <= (action_in == ACT_TRANSMIT) ? port_mac_ff : '0;
         rsp_hdr_proto_ff  <= (action_in == ACT_TRANSMIT) ? ptype_ff : '0;
         rsp_packet_ref_ff <= (action_in != ACT_NONE) ? pid_ff : '0;
         rsp_target_ip_ff  <= (action_in == ACT_HOLD) ? key_ff : '0;
         rsp_sender_ip_ff  <= (action_in == ACT_HOLD) ? port_ip_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_action_ff, rsp_status_ff};
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_waiting_ff, rsp_resolved_ff,
                        rsp_sender_ip_ff, rsp_target_ip_ff, rsp_packet_ref_ff,
                        rsp_hdr_proto_ff, rsp_src_mac_ff, rsp_dst_mac_ff};

   // Checks
   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("request accepted during clearing sweep");

   a_hash_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == S_HASH))
      else $error("bucket index finished outside of index wait");

   a_hold_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_action_ff == ACT_HOLD) |-> (rsp_waiting_ff != '0))
      else $error("held packet with zero waiting count");

   a_transmit_resolved: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_action_ff == ACT_TRANSMIT) |-> rsp_resolved_ff)
      else $error("transmit to unresolved neighbor");

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != S_CLEAR) |-> (state_ff == S_UPDATE) ##1 (state_ff == S_IDLE))
      else $error("row write-back outside of update cycle");
endmodule

// File: design/ntr_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing.
module ntr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/ntr_bucket_hash.sv
// Bucket index unit: key mod BUCKETS, a mask for a power-of-two bucket count,
// otherwise a three-stage reciprocal multiply with one final correction.
// Depends on ntr_pkg.
module ntr_bucket_hash #(
   parameter int BUCKETS = ntr_pkg::DEF_BUCKETS,
   parameter int BKT_W   = $clog2(BUCKETS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ntr_pkg::KEY_W-1:0] key,
   output logic                     done,
   output logic [BKT_W-1:0]         bucket
);
   import ntr_pkg::*;

   generate
      if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
         logic             done_ff;
         logic [BKT_W-1:0] bucket_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               bucket_ff <= key[BKT_W-1:0];
            end
         end

         assign done   = done_ff;
         assign bucket = bucket_ff;
      end else begin : g_rem
         // floor(2^32 / BUCKETS): the estimated quotient is low by at most one
         localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / 64'(BUCKETS));
         localparam logic [BKT_W:0]   DIVISOR = (BKT_W+1)'(BUCKETS);

         logic [2:0]         vld_ff;
         logic               done_ff;
         logic [KEY_W-1:0]   key_ff;
         logic [KEY_W-1:0]   quot_ff, quot_in;
         logic [2*KEY_W-1:0] prod;
         logic [BKT_W:0]     rem_ff, rem_in;
         logic [BKT_W-1:0]   bucket_ff, bucket_in;

         // Quotient estimate, partial remainder below 2*BUCKETS, final fix-up
         always_comb begin
            prod      = {{KEY_W{1'b0}}, key_ff} * {{KEY_W{1'b0}}, RECIP};
            quot_in   = prod[2*KEY_W-1:KEY_W];
            rem_in    = key_ff[BKT_W:0] - quot_ff[BKT_W:0] * DIVISOR;
            bucket_in = (rem_ff >= DIVISOR) ? BKT_W'(rem_ff - DIVISOR) : rem_ff[BKT_W-1:0];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff  <= '0;
               done_ff <= 1'b0;
            end else begin
               vld_ff  <= {vld_ff[1:0], start};
               done_ff <= vld_ff[2];
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               key_ff <= key;
            end
            if (vld_ff[0]) begin
               quot_ff <= quot_in;
            end
            if (vld_ff[1]) begin
               rem_ff <= rem_in;
            end
            if (vld_ff[2]) begin
               bucket_ff <= bucket_in;
            end
         end

         assign done   = done_ff;
         assign bucket = bucket_ff;
      end
   endgenerate
endmodule

// File: design/ntr_way_match.sv
// Parallel compare of a bucket row: lowest used way holding the key, and
// lowest free way. Depends on ntr_pkg.
module ntr_way_match #(
   parameter int WAYS  = ntr_pkg::DEF_WAYS,
   parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic [ntr_pkg::KEY_W-1:0]        key,
   input  logic [WAYS-1:0]                  used,
   input  ntr_pkg::entry_type [WAYS-1:0]    ents,
   output ntr_pkg::match_flags_type         flags,
   output logic [WAY_W-1:0]                 hit_way,
   output logic [WAY_W-1:0]                 free_way
);
   import ntr_pkg::*;

   // Scan from the top so the lowest way wins
   always_comb begin
      flags    = '0;
      hit_way  = '0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (used[w] && ents[w].key == key) begin
            flags.hit = 1'b1;
            hit_way   = WAY_W'(w);
         end
         if (!used[w]) begin
            flags.room = 1'b1;
            free_way   = WAY_W'(w);
         end
      end
   end
endmodule
